### hw/rtl/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg: shared types and helpers for the 3D vector arithmetic unit
// Request/response structs, opcodes, status codes, widths and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package v3au_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 64;
  localparam int unsigned WIDE_W        = 66;
  localparam int unsigned LEN_W         = 33;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned SQRT_LAT      = SQRT_STEPS + 1;
  localparam int unsigned LANES         = 3;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_SCALE  = 3'd2,
    MODE_DIV    = 3'd3,
    MODE_LENGTH = 3'd4,
    MODE_NORM   = 3'd5,
    MODE_DOT    = 3'd6,
    MODE_CROSS  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_ZERO_VEC = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    status_e            status;
    logic               overflow;
  } rsp_t;

  // Saturated 32-bit value plus its overflow flag
  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    logic [WIDE_W-DATA_W:0] top;
    top   = v[WIDE_W-1:DATA_W-1];
    r.ov  = !((&top) || (~|top));
    if (r.ov) begin
      r.val = v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/v3au_lane.sv
// ----------------------------------------------------------------------------
// v3au_lane: one component lane
// Multiplier stage (two products, add/sub), then rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_lane #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire v3au_pkg::mode_e    mode_i,
  input  wire logic signed [31:0] m0a_i,
  input  wire logic signed [31:0] m0b_i,
  input  wire logic signed [31:0] m1a_i,
  input  wire logic signed [31:0] m1b_i,
  input  wire logic signed [31:0] add_a_i,
  input  wire logic signed [31:0] add_b_i,
  output logic signed [63:0]      prod_o,
  output v3au_pkg::sat_t          res_o
);

  localparam logic signed [64:0] HALF = 65'(1) <<< (FRAC_BITS - 1);

  logic signed [63:0] p0_q, p1_q;
  logic signed [32:0] sum_q;
  v3au_pkg::mode_e    mode_q;
  logic signed [64:0] diff, rnd;
  v3au_pkg::sat_t     res_d, res_q;

  always_ff @(posedge clk_i) begin
    p0_q   <= m0a_i * m0b_i;
    p1_q   <= m1a_i * m1b_i;
    if (mode_i == v3au_pkg::MODE_SUB) begin
      sum_q <= 33'(add_a_i) - 33'(add_b_i);
    end else begin
      sum_q <= 33'(add_a_i) + 33'(add_b_i);
    end
    mode_q <= mode_i;
  end

  // round half up to FRAC_BITS fraction bits
  assign diff = 65'(p0_q) - 65'(p1_q);
  assign rnd  = (diff + HALF) >>> FRAC_BITS;

  always_comb begin
    case (mode_q) inside
      v3au_pkg::MODE_ADD, v3au_pkg::MODE_SUB: begin
        res_d = v3au_pkg::sat32(v3au_pkg::WIDE_W'(sum_q));
      end
      v3au_pkg::MODE_SCALE, v3au_pkg::MODE_CROSS: begin
        res_d = v3au_pkg::sat32(v3au_pkg::WIDE_W'(rnd));
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign prod_o = p0_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

### hw/rtl/v3au_sqrt.sv
// ----------------------------------------------------------------------------
// v3au_sqrt: pipelined integer square root
// One result bit per stage over a 64-bit radicand, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_sqrt (
  input  wire logic        clk_i,
  input  wire logic [63:0] rad_i,
  output logic [32:0]      len_o
);

  localparam int unsigned N = v3au_pkg::SQRT_STEPS;

  logic [32:0] rem_q  [N];
  logic [31:0] root_q [N];
  logic [63:0] rad_q  [N];
  logic [32:0] len_q;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [32:0] rem_prev;
    logic [31:0] root_prev;
    logic [63:0] rad_prev;
    logic [34:0] rem_sh, trial;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = rad_i;
    end else begin : g_next
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign rad_prev  = rad_q[k-1];
    end

    assign rem_sh = {rem_prev, rad_prev[63:62]};
    assign trial  = {1'b0, root_prev, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? 33'(rem_sh - trial) : rem_sh[32:0];
      root_q[k] <= {root_prev[30:0], take};
      rad_q[k]  <= {rad_prev[61:0], 2'b00};
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk_i) begin
    len_q <= {1'b0, root_q[N-1]} + 33'(rem_q[N-1] > {1'b0, root_q[N-1]});
  end

  assign len_o = len_q;

endmodule

`default_nettype wire

### hw/rtl/v3au_div.sv
// ----------------------------------------------------------------------------
// v3au_div: pipelined restoring divider
// One quotient bit per stage; quotient shifts in behind the numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_div #(
  parameter int unsigned NUM_W = 49
) (
  input  wire logic                        clk_i,
  input  wire logic [NUM_W-1:0]            num_i,
  input  wire logic [v3au_pkg::LEN_W-1:0]  den_i,
  output logic [NUM_W-1:0]                 quo_o
);

  localparam int unsigned DW = v3au_pkg::LEN_W;

  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DW-1:0]    den_q [NUM_W];
  logic [DW-1:0]    rem_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [NUM_W-1:0] num_prev;
    logic [DW-1:0]    den_prev, rem_prev;
    logic [DW:0]      rem_sh;
    logic             take;

    if (k == 0) begin : g_first
      assign num_prev = num_i;
      assign den_prev = den_i;
      assign rem_prev = '0;
    end else begin : g_next
      assign num_prev = num_q[k-1];
      assign den_prev = den_q[k-1];
      assign rem_prev = rem_q[k-1];
    end

    assign rem_sh = {rem_prev, num_prev[NUM_W-1]};
    assign take   = rem_sh >= {1'b0, den_prev};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? DW'(rem_sh - {1'b0, den_prev}) : rem_sh[DW-1:0];
      num_q[k] <= {num_prev[NUM_W-2:0], take};
      den_q[k] <= den_prev;
    end
  end

  assign quo_o = num_q[NUM_W-1];

endmodule

`default_nettype wire

### hw/rtl/vector3_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_core: pipelined 3D vector ALU, signed fixed point
// Add, sub, scale, divide, length, normalize, dot and cross on Q(32-F).F data.
// ----------------------------------------------------------------------------
//
//  Channel   | Ports                  | Handshake
//  ----------+------------------------+-------------------------------------
//  request   | start, busy, req_i     | taken on a clock edge with start & !busy
//  response  | rsp_valid_o, rsp_o     | one-cycle strobe, cannot be held off
//
//  Cycles : fully pipelined, one request per clock. The pipeline is
//           the multiplier stage, rounding/merge stage, 33-stage square
//           root, a divider stage per quotient bit (FRAC_BITS + 33 of
//           them) and the output register.
//  Reset  : rst_ni clears the valid pipeline only; data stages are not reset.
//  Stalls : none; busy is always low and responses leave in request order.
//
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_arithmetic_unit_core #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire v3au_pkg::req_t req_i,
  output logic                rsp_valid_o,
  output v3au_pkg::rsp_t      rsp_o
);

  localparam int unsigned NUM_W = v3au_pkg::DATA_W + FRAC_BITS + 1;
  localparam int unsigned LAT   = v3au_pkg::SQRT_LAT + NUM_W + 3;
  localparam logic signed [v3au_pkg::WIDE_W-1:0] HALF =
    v3au_pkg::WIDE_W'(1) <<< (FRAC_BITS - 1);

  // Stage B record (goes with the radicand into the square root)
  typedef struct packed {
    v3au_pkg::mode_e       mode;
    logic [2:0]            a_neg;
    logic [2:0][31:0]      a_mag;
    logic                  s_neg;
    logic [31:0]           s_mag;
    v3au_pkg::sat_t        dot;
    logic [63:0]           sumsq;
  } stb_t;

  // Record carried beside the square root
  typedef struct packed {
    v3au_pkg::mode_e       mode;
    logic [2:0]            a_neg;
    logic [2:0][31:0]      a_mag;
    logic                  s_neg;
    logic [31:0]           s_mag;
    v3au_pkg::sat_t [2:0]  vec;
    v3au_pkg::sat_t        dot;
  } mid_t;

  // Record carried beside the dividers
  typedef struct packed {
    v3au_pkg::mode_e       mode;
    logic [2:0]            a_neg;
    logic                  s_neg;
    logic                  s_zero;
    v3au_pkg::sat_t [2:0]  vec;
    v3au_pkg::sat_t        dot;
    logic [32:0]           len;
  } fin_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Valid pipeline: the only reset state
  // --------------------------------------------------------------------------
  logic [LAT-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: operand select and multiply in three lanes
  // --------------------------------------------------------------------------
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];
  assign in_a[0] = req_i.a_x;
  assign in_a[1] = req_i.a_y;
  assign in_a[2] = req_i.a_z;
  assign in_b[0] = req_i.b_x;
  assign in_b[1] = req_i.b_y;
  assign in_b[2] = req_i.b_z;

  logic signed [63:0]  prod [3];
  v3au_pkg::sat_t      lane_res [3];

  v3au_pkg::mode_e     mode_a_q;
  logic signed [31:0]  a_a_q [3];
  logic signed [31:0]  s_a_q;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    localparam int C1 = (c + 1) % 3;
    localparam int C2 = (c + 2) % 3;
    logic signed [31:0] m0a, m0b, m1a, m1b;

    // cross: a[c+1]*b[c+2] - a[c+2]*b[c+1]
    always_comb begin
      m0a = in_a[c];
      m0b = in_b[c];
      m1a = '0;
      m1b = '0;
      case (req_i.mode)
        v3au_pkg::MODE_SCALE:  m0b = req_i.scale_factor;
        v3au_pkg::MODE_LENGTH: m0b = in_a[c];
        v3au_pkg::MODE_NORM:   m0b = in_a[c];
        v3au_pkg::MODE_CROSS: begin
          m0a = in_a[C1];
          m0b = in_b[C2];
          m1a = in_a[C2];
          m1b = in_b[C1];
        end
        default: ;
      endcase
    end

    v3au_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .mode_i  (req_i.mode),
      .m0a_i   (m0a),
      .m0b_i   (m0b),
      .m1a_i   (m1a),
      .m1b_i   (m1b),
      .add_a_i (in_a[c]),
      .add_b_i (in_b[c]),
      .prod_o  (prod[c]),
      .res_o   (lane_res[c])
    );

    always_ff @(posedge clk_i) begin
      a_a_q[c] <= in_a[c];
    end
  end

  always_ff @(posedge clk_i) begin
    mode_a_q <= req_i.mode;
    s_a_q    <= req_i.scale_factor;
  end

  // --------------------------------------------------------------------------
  // Stage B: merge lane products (dot sum, sum of squares), magnitudes
  // --------------------------------------------------------------------------
  logic signed [v3au_pkg::WIDE_W-1:0] prod_sum, dot_rnd;
  stb_t stb_d, stb_q;

  assign prod_sum = v3au_pkg::WIDE_W'(prod[0]) + v3au_pkg::WIDE_W'(prod[1])
                  + v3au_pkg::WIDE_W'(prod[2]);
  assign dot_rnd  = (prod_sum + HALF) >>> FRAC_BITS;

  always_comb begin
    stb_d.mode  = mode_a_q;
    for (int c = 0; c < 3; c++) begin
      stb_d.a_neg[c] = a_a_q[c][31];
      stb_d.a_mag[c] = a_a_q[c][31] ? 32'(-a_a_q[c]) : a_a_q[c];
    end
    stb_d.s_neg = s_a_q[31];
    stb_d.s_mag = s_a_q[31] ? 32'(-s_a_q) : s_a_q;
    stb_d.dot   = v3au_pkg::sat32(dot_rnd);
    stb_d.sumsq = prod_sum[63:0];
  end

  always_ff @(posedge clk_i) begin
    stb_q <= stb_d;
  end

  // --------------------------------------------------------------------------
  // Square root of the sum of squares, record delayed beside it
  // --------------------------------------------------------------------------
  logic [32:0] len;
  mid_t        mid_in;
  mid_t        mid_q [v3au_pkg::SQRT_LAT];

  v3au_sqrt u_sqrt (
    .clk_i (clk_i),
    .rad_i (stb_q.sumsq),
    .len_o (len)
  );

  always_comb begin
    mid_in.mode  = stb_q.mode;
    mid_in.a_neg = stb_q.a_neg;
    mid_in.a_mag = stb_q.a_mag;
    mid_in.s_neg = stb_q.s_neg;
    mid_in.s_mag = stb_q.s_mag;
    mid_in.dot   = stb_q.dot;
    for (int c = 0; c < 3; c++) begin
      mid_in.vec[c] = lane_res[c];
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q[0] <= mid_in;
    for (int i = 1; i < int'(v3au_pkg::SQRT_LAT); i++) begin
      mid_q[i] <= mid_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: |a| * 2^F / divisor, rounded half away from zero via d/2 bias
  // --------------------------------------------------------------------------
  mid_t                           mid;
  logic [v3au_pkg::LEN_W-1:0]     den;
  logic [NUM_W-1:0]               quo [3];
  fin_t                           fin_in;
  fin_t                           fin_q [NUM_W];

  assign mid = mid_q[v3au_pkg::SQRT_LAT-1];
  assign den = (mid.mode == v3au_pkg::MODE_DIV) ? {1'b0, mid.s_mag} : len;

  for (genvar c = 0; c < 3; c++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = (NUM_W'(mid.a_mag[c]) << FRAC_BITS) + NUM_W'(den >> 1);

    v3au_div #(
      .NUM_W (NUM_W)
    ) u_div (
      .clk_i (clk_i),
      .num_i (num),
      .den_i (den),
      .quo_o (quo[c])
    );
  end

  always_comb begin
    fin_in.mode   = mid.mode;
    fin_in.a_neg  = mid.a_neg;
    fin_in.s_neg  = mid.s_neg;
    fin_in.s_zero = (mid.s_mag == '0);
    fin_in.vec    = mid.vec;
    fin_in.dot    = mid.dot;
    fin_in.len    = len;
  end

  always_ff @(posedge clk_i) begin
    fin_q[0] <= fin_in;
    for (int i = 1; i < int'(NUM_W); i++) begin
      fin_q[i] <= fin_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output select, sign and saturation
  // --------------------------------------------------------------------------
  fin_t            fin;
  v3au_pkg::sat_t  qs [3];
  v3au_pkg::sat_t  len_sat;
  v3au_pkg::rsp_t  rsp_d, rsp_q;
  v3au_pkg::mode_e out_mode_q;

  assign fin     = fin_q[NUM_W-1];
  assign len_sat = v3au_pkg::sat32(v3au_pkg::WIDE_W'(fin.len));

  for (genvar c = 0; c < 3; c++) begin : g_qsat
    logic                               neg;
    logic signed [v3au_pkg::WIDE_W-1:0] qw;
    assign neg    = fin.a_neg[c] ^ ((fin.mode == v3au_pkg::MODE_DIV) & fin.s_neg);
    assign qw     = v3au_pkg::WIDE_W'(quo[c]);
    assign qs[c]  = v3au_pkg::sat32(neg ? -qw : qw);
  end

  always_comb begin
    rsp_d = '0;
    case (fin.mode) inside
      v3au_pkg::MODE_ADD, v3au_pkg::MODE_SUB, v3au_pkg::MODE_SCALE,
      v3au_pkg::MODE_CROSS: begin
        rsp_d.res_x    = fin.vec[0].val;
        rsp_d.res_y    = fin.vec[1].val;
        rsp_d.res_z    = fin.vec[2].val;
        rsp_d.overflow = fin.vec[0].ov | fin.vec[1].ov | fin.vec[2].ov;
      end
      v3au_pkg::MODE_DOT: begin
        rsp_d.res_scalar = fin.dot.val;
        rsp_d.overflow   = fin.dot.ov;
      end
      v3au_pkg::MODE_LENGTH: begin
        rsp_d.res_scalar = len_sat.val;
        rsp_d.overflow   = len_sat.ov;
      end
      v3au_pkg::MODE_DIV, v3au_pkg::MODE_NORM: begin
        if ((fin.mode == v3au_pkg::MODE_DIV) && fin.s_zero) begin
          rsp_d.status = v3au_pkg::STAT_DIV_ZERO;
        end else if ((fin.mode == v3au_pkg::MODE_NORM) && (fin.len == '0)) begin
          rsp_d.status = v3au_pkg::STAT_ZERO_VEC;
        end else begin
          rsp_d.res_x    = qs[0].val;
          rsp_d.res_y    = qs[1].val;
          rsp_d.res_z    = qs[2].val;
          rsp_d.overflow = qs[0].ov | qs[1].ov | qs[2].ov;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rsp_q      <= rsp_d;
    out_mode_q <= fin.mode;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = vld_q[LAT-1];

`ifndef SYNTHESIS
  // every response traces back to an accepted request
  a_resp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, LAT))
    else $error("response without a matching request");

  // error status forces zero results and no overflow
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != v3au_pkg::STAT_OK)) |->
      ((rsp_o.res_x == '0) && (rsp_o.res_y == '0) && (rsp_o.res_z == '0) &&
       (rsp_o.res_scalar == '0) && !rsp_o.overflow))
    else $error("error status with nonzero result");

  // vector opcodes leave the scalar field at zero
  a_vec_scalar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && ((out_mode_q == v3au_pkg::MODE_ADD) ||
                     (out_mode_q == v3au_pkg::MODE_SUB) ||
                     (out_mode_q == v3au_pkg::MODE_CROSS))) |->
      (rsp_o.res_scalar == '0))
    else $error("vector opcode drove the scalar result");

  // length is never negative
  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (out_mode_q == v3au_pkg::MODE_LENGTH)) |->
      !rsp_o.res_scalar[31])
    else $error("negative length");
`endif

endmodule

`default_nettype wire
